[design/vns_pkg.sv]
// vns_pkg: shared types and codes for the vertex normal smoothing core
// item and result structs, function and status codes, controller/datapath link
// no dependencies
`timescale 1ns / 1ps

package vns_pkg;

    localparam int IDX_W = 10;

    // function codes of an input transaction
    localparam logic [1:0] FN_LOAD  = 2'd0;
    localparam logic [1:0] FN_FACE  = 2'd1;
    localparam logic [1:0] FN_READ  = 2'd2;
    localparam logic [1:0] FN_CLEAR = 2'd3;

    // status codes of a result transaction
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INDEX = 2'd1;
    localparam logic [1:0] ST_DEGEN = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [1:0]        func;
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
        logic signed [15:0] coord_z;
        logic [IDX_W-1:0]  vert_a;
        logic [IDX_W-1:0]  vert_b;
        logic [IDX_W-1:0]  vert_c;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic [1:0]        status;
    } out_item_t;

    // datapath operations
    typedef enum logic [4:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_LOAD,
        DP_CLEAR,
        DP_VRD,
        DP_VLT,
        DP_EDGE,
        DP_MUL,
        DP_XLOAD,
        DP_SRD,
        DP_SLOAD,
        DP_SHIFT,
        DP_SQ,
        DP_SQRT_INIT,
        DP_SQRT_STEP,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_SWR,
        DP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] sel;
        logic [2:0] step;
        logic [1:0] status;
        logic       norm_en;
    } dp_cmd_t;

    typedef struct packed {
        logic       full;
        logic       idx_bad;
        logic       vec_zero;
        logic       shift_done;
        logic [1:0] func;
    } dp_stat_t;

endpackage

[design/vns_ram.sv]
// vns_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module vns_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/vns_dp.sv]
// vns_dp: datapath of the vertex normal smoothing core
// vertex and sum rams, cross product, normalize (shift, squares, sqrt, divide)
// depends on vns_pkg and vns_ram
`timescale 1ns / 1ps

module vns_dp #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  vns_pkg::in_item_t  item_in,
    input  vns_pkg::dp_cmd_t   cmd,
    output vns_pkg::dp_stat_t  stat,
    output vns_pkg::out_item_t result_out
);

    import vns_pkg::*;

    localparam int AW   = $clog2(MAX_VERTICES);
    localparam int CW   = $clog2(MAX_VERTICES + 1);
    localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

    function automatic logic signed [16:0] sub17(input logic [15:0] a, input logic [15:0] b);
        sub17 = $signed({a[15], a}) - $signed({b[15], b});
    endfunction

    function automatic logic [35:0] abs36(input logic [35:0] v);
        abs36 = v[35] ? (36'd0 - v) : v;
    endfunction

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] d);
        logic [32:0] s;
        s = {a[31], a} + {{17{d[15]}}, d};
        if (s[32] != s[31])
            sat_add = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            sat_add = s[31:0];
    endfunction

    logic [CW-1:0]    count_reg;
    in_item_t         item_reg;
    logic [47:0]      vtx_reg [3];
    logic signed [16:0] e_reg [6];
    logic [35:0]      cr_reg [3];
    logic [35:0]      mag_reg [3];
    logic             neg_reg [3];
    logic [63:0]      sq_reg;
    logic [63:0]      v_reg;
    logic [63:0]      r_reg;
    logic [63:0]      b_reg;
    logic [47:0]      rem_reg [3];
    logic [47:0]      dsh_reg;
    logic [16:0]      q_reg [3];
    out_item_t        out_reg;

    logic [IDX_W-1:0] idx_sel;
    logic [47:0]      vram_rdata;
    logic [95:0]      sram_rdata;
    logic             sram_we;
    logic [AW-1:0]    sram_waddr;
    logic [95:0]      sram_wdata;
    logic [31:0]      sum_word [3];
    logic signed [16:0] opa;
    logic signed [16:0] opb;
    logic signed [33:0] prod;
    logic [35:0]      prod36;
    logic [31:0]      mag_sel;
    logic [63:0]      sq_prod;
    logic [63:0]      root_try;
    logic [14:0]      q_clamp [3];
    logic [15:0]      unit [3];
    logic             full;
    logic             bad_a;
    logic             bad_b;
    logic             bad_c;

    // index chosen by the controller
    always_comb
    begin
        case (cmd.sel)
            2'd0:    idx_sel = item_reg.vert_a;
            2'd1:    idx_sel = item_reg.vert_b;
            default: idx_sel = item_reg.vert_c;
        endcase
    end

    // bounds checks against the loaded vertex count
    assign full  = count_reg >= CW'(MAX_VERTICES);
    assign bad_a = CMPW'(item_reg.vert_a) >= CMPW'(count_reg);
    assign bad_b = CMPW'(item_reg.vert_b) >= CMPW'(count_reg);
    assign bad_c = CMPW'(item_reg.vert_c) >= CMPW'(count_reg);

    // status to the controller
    always_comb
    begin
        stat.full       = full;
        stat.func       = item_reg.func;
        stat.vec_zero   = (mag_reg[0] == 36'd0) && (mag_reg[1] == 36'd0)
                          && (mag_reg[2] == 36'd0);
        stat.shift_done = (mag_reg[0] <= 36'h0_8000_0000) && (mag_reg[1] <= 36'h0_8000_0000)
                          && (mag_reg[2] <= 36'h0_8000_0000);
        case (item_reg.func)
            FN_FACE: stat.idx_bad = bad_a | bad_b | bad_c;
            FN_READ: stat.idx_bad = bad_a;
            default: stat.idx_bad = 1'b0;
        endcase
    end

    // vertex store
    vns_ram #(.WIDTH(48), .DEPTH(MAX_VERTICES)) u_vram (
        .clk   (clk),
        .we    (cmd.op == DP_LOAD),
        .waddr (AW'(count_reg)),
        .wdata ({item_reg.coord_x, item_reg.coord_y, item_reg.coord_z}),
        .raddr (AW'(idx_sel)),
        .rdata (vram_rdata)
    );

    // accumulator store, x y z side by side
    vns_ram #(.WIDTH(96), .DEPTH(MAX_VERTICES)) u_sram (
        .clk   (clk),
        .we    (sram_we),
        .waddr (sram_waddr),
        .wdata (sram_wdata),
        .raddr (AW'(idx_sel)),
        .rdata (sram_rdata)
    );

    assign sum_word[0] = sram_rdata[95:64];
    assign sum_word[1] = sram_rdata[63:32];
    assign sum_word[2] = sram_rdata[31:0];

    // unit vector lanes from the quotients
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            q_clamp[i] = (q_reg[i] > 17'd32767) ? 15'h7FFF : q_reg[i][14:0];
            unit[i]    = neg_reg[i] ? (16'd0 - {1'b0, q_clamp[i]}) : {1'b0, q_clamp[i]};
        end
    end

    // accumulator write: zero on load, saturated add otherwise
    assign sram_we    = (cmd.op == DP_LOAD) || (cmd.op == DP_SWR);
    assign sram_waddr = (cmd.op == DP_LOAD) ? AW'(count_reg) : AW'(idx_sel);
    assign sram_wdata = (cmd.op == DP_LOAD) ? 96'd0
                      : {sat_add(sum_word[0], unit[0]), sat_add(sum_word[1], unit[1]),
                         sat_add(sum_word[2], unit[2])};

    // shared cross product multiplier
    always_comb
    begin
        case (cmd.step)
            3'd0:    begin opa = e_reg[1]; opb = e_reg[5]; end
            3'd1:    begin opa = e_reg[2]; opb = e_reg[4]; end
            3'd2:    begin opa = e_reg[2]; opb = e_reg[3]; end
            3'd3:    begin opa = e_reg[0]; opb = e_reg[5]; end
            3'd4:    begin opa = e_reg[0]; opb = e_reg[4]; end
            default: begin opa = e_reg[1]; opb = e_reg[3]; end
        endcase
    end

    assign prod    = opa * opb;
    assign prod36  = {{2{prod[33]}}, prod};
    assign mag_sel = mag_reg[cmd.step[1:0]][31:0];
    assign sq_prod = mag_sel * mag_sel;
    assign root_try = r_reg + b_reg;
    assign result_out = out_reg;

    // vertex count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.op == DP_LOAD)
        begin
            count_reg <= count_reg + CW'(1);
        end
        else if (cmd.op == DP_CLEAR)
        begin
            count_reg <= '0;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            DP_CAPTURE:
            begin
                item_reg <= item_in;
            end
            DP_VLT:
            begin
                vtx_reg[cmd.sel] <= vram_rdata;
            end
            DP_EDGE:
            begin
                e_reg[0] <= sub17(vtx_reg[1][47:32], vtx_reg[0][47:32]);
                e_reg[1] <= sub17(vtx_reg[1][31:16], vtx_reg[0][31:16]);
                e_reg[2] <= sub17(vtx_reg[1][15:0],  vtx_reg[0][15:0]);
                e_reg[3] <= sub17(vtx_reg[2][47:32], vtx_reg[0][47:32]);
                e_reg[4] <= sub17(vtx_reg[2][31:16], vtx_reg[0][31:16]);
                e_reg[5] <= sub17(vtx_reg[2][15:0],  vtx_reg[0][15:0]);
            end
            DP_MUL:
            begin
                if (!cmd.step[0])
                    cr_reg[cmd.step[2:1]] <= prod36;
                else
                    cr_reg[cmd.step[2:1]] <= cr_reg[cmd.step[2:1]] - prod36;
            end
            DP_XLOAD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mag_reg[i] <= abs36(cr_reg[i]);
                    neg_reg[i] <= cr_reg[i][35];
                end
            end
            DP_SLOAD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mag_reg[i] <= abs36({{4{sum_word[i][31]}}, sum_word[i]});
                    neg_reg[i] <= sum_word[i][31];
                end
            end
            DP_SHIFT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mag_reg[i] <= mag_reg[i] >> 1;
                end
            end
            DP_SQ:
            begin
                sq_reg <= ((cmd.step == 3'd0) ? 64'd0 : sq_reg) + sq_prod;
            end
            DP_SQRT_INIT:
            begin
                v_reg <= sq_reg;
                r_reg <= 64'd0;
                b_reg <= 64'h4000_0000_0000_0000;
            end
            DP_SQRT_STEP:
            begin
                if (v_reg >= root_try)
                begin
                    v_reg <= v_reg - root_try;
                    r_reg <= (r_reg >> 1) + b_reg;
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
                b_reg <= b_reg >> 2;
            end
            DP_DIV_INIT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rem_reg[i] <= {1'b0, mag_reg[i][31:0], 15'd0} + {17'd0, r_reg[31:1]};
                    q_reg[i]   <= 17'd0;
                end
                dsh_reg <= {r_reg[31:0], 16'd0};
            end
            DP_DIV_STEP:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (rem_reg[i] >= dsh_reg)
                    begin
                        rem_reg[i] <= rem_reg[i] - dsh_reg;
                        q_reg[i]   <= {q_reg[i][15:0], 1'b1};
                    end
                    else
                    begin
                        q_reg[i] <= {q_reg[i][15:0], 1'b0};
                    end
                end
                dsh_reg <= dsh_reg >> 1;
            end
            DP_RESULT:
            begin
                out_reg.status <= cmd.status;
                out_reg.norm_x <= cmd.norm_en ? unit[0] : 16'd0;
                out_reg.norm_y <= cmd.norm_en ? unit[1] : 16'd0;
                out_reg.norm_z <= cmd.norm_en ? unit[2] : 16'd0;
            end
            default:
            begin
            end
        endcase
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_VERTICES))
        else $error("vertex count beyond store depth");

    a_load_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_LOAD) |-> !full)
        else $error("load issued into a full store");

endmodule

[design/vns_ctrl.sv]
// vns_ctrl: controller state machine of the vertex normal smoothing core
// sequences the datapath and owns both handshakes
// depends on vns_pkg
`timescale 1ns / 1ps

module vns_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    output logic              result_valid,
    input  logic              result_stall,
    input  vns_pkg::dp_stat_t stat,
    output vns_pkg::dp_cmd_t  cmd
);

    import vns_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_VRD,
        S_VLT,
        S_EDGE,
        S_MUL,
        S_XLOAD,
        S_SRD,
        S_SLOAD,
        S_SHIFT,
        S_SQ,
        S_SQRT_INIT,
        S_SQRT,
        S_DIV_INIT,
        S_DIV,
        S_ACC_RD,
        S_ACC_WR,
        S_RESULT
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [5:0] cnt_reg;
    logic [5:0] cnt_next;
    logic [1:0] sel_reg;
    logic [1:0] sel_next;
    logic [1:0] res_status_reg;
    logic [1:0] res_status_next;
    logic       res_norm_reg;
    logic       res_norm_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free     = !out_valid_reg || !result_stall;
    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;

    // next state and datapath command
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        sel_next        = sel_reg;
        res_status_next = res_status_reg;
        res_norm_next   = res_norm_reg;
        out_valid_next  = out_valid_reg && result_stall;
        cmd.op          = DP_NOP;
        cmd.sel         = sel_reg;
        cmd.step        = cnt_reg[2:0];
        cmd.status      = res_status_reg;
        cmd.norm_en     = res_norm_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.op     = DP_CAPTURE;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                res_norm_next   = 1'b0;
                res_status_next = ST_OK;
                sel_next        = 2'd0;
                state_next      = S_RESULT;
                unique case (stat.func)
                    FN_LOAD:
                    begin
                        if (stat.full)
                            res_status_next = ST_FULL;
                        else
                            cmd.op = DP_LOAD;
                    end
                    FN_FACE:
                    begin
                        if (stat.idx_bad)
                            res_status_next = ST_INDEX;
                        else
                            state_next = S_VRD;
                    end
                    FN_READ:
                    begin
                        if (stat.idx_bad)
                            res_status_next = ST_INDEX;
                        else
                            state_next = S_SRD;
                    end
                    default:
                    begin
                        cmd.op = DP_CLEAR;
                    end
                endcase
            end
            S_VRD:
            begin
                cmd.op     = DP_VRD;
                state_next = S_VLT;
            end
            S_VLT:
            begin
                cmd.op = DP_VLT;
                if (sel_reg == 2'd2)
                begin
                    cnt_next   = 6'd0;
                    state_next = S_EDGE;
                end
                else
                begin
                    sel_next   = sel_reg + 2'd1;
                    state_next = S_VRD;
                end
            end
            S_EDGE:
            begin
                cmd.op     = DP_EDGE;
                cnt_next   = 6'd0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.op = DP_MUL;
                if (cnt_reg == 6'd5)
                    state_next = S_XLOAD;
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            S_XLOAD:
            begin
                cmd.op     = DP_XLOAD;
                state_next = S_SHIFT;
            end
            S_SRD:
            begin
                cmd.op     = DP_SRD;
                state_next = S_SLOAD;
            end
            S_SLOAD:
            begin
                cmd.op     = DP_SLOAD;
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                if (stat.vec_zero)
                begin
                    res_status_next = (stat.func == FN_FACE) ? ST_DEGEN : ST_OK;
                    state_next      = S_RESULT;
                end
                else if (!stat.shift_done)
                begin
                    cmd.op = DP_SHIFT;
                end
                else
                begin
                    cnt_next   = 6'd0;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                cmd.op = DP_SQ;
                if (cnt_reg == 6'd2)
                    state_next = S_SQRT_INIT;
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            S_SQRT_INIT:
            begin
                cmd.op     = DP_SQRT_INIT;
                cnt_next   = 6'd0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.op = DP_SQRT_STEP;
                if (cnt_reg == 6'd31)
                    state_next = S_DIV_INIT;
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            S_DIV_INIT:
            begin
                cmd.op     = DP_DIV_INIT;
                cnt_next   = 6'd0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op = DP_DIV_STEP;
                if (cnt_reg == 6'd16)
                begin
                    res_status_next = ST_OK;
                    if (stat.func == FN_FACE)
                    begin
                        sel_next   = 2'd0;
                        state_next = S_ACC_RD;
                    end
                    else
                    begin
                        res_norm_next = 1'b1;
                        state_next    = S_RESULT;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            S_ACC_RD:
            begin
                cmd.op     = DP_SRD;
                state_next = S_ACC_WR;
            end
            S_ACC_WR:
            begin
                cmd.op = DP_SWR;
                if (sel_reg == 2'd2)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    sel_next   = sel_reg + 2'd1;
                    state_next = S_ACC_RD;
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    cmd.op         = DP_RESULT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= 6'd0;
            sel_reg        <= 2'd0;
            res_status_reg <= ST_OK;
            res_norm_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            sel_reg        <= sel_next;
            res_status_reg <= res_status_next;
            res_norm_reg   <= res_norm_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_RESULT) |-> out_free)
        else $error("result written over a waiting transaction");

    a_valid_from_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> ($past(state_reg) == S_RESULT))
        else $error("result valid raised outside the result state");

    a_sqrt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQRT) |-> (cnt_reg <= 6'd31))
        else $error("square root step count overrun");

endmodule

[design/vertex_normal_smoothing_core.sv]
// vertex_normal_smoothing_core: top level, averaged per-vertex normals
// channel    | valid        | stall        | payload
// item       | item_valid   | item_stall   | item   (vns_pkg::in_item_t)
// result     | result_valid | result_stall | result (vns_pkg::out_item_t)
// result valid follows the dispatch and result states for load, clear, full store and bad index
// a face runs three vertex reads, 1 edge step, 6 steps of the shared 17x17 multiplier,
// up to 2 shift steps plus a check, 3 squares, 32 square root steps, 17 divide steps
// (three lanes in parallel) and an accumulator read and write per vertex;
// a degenerate face ends at the shift check, as does a read whose sum is zero
// reset clears control state and vertex count only; a waiting result does not
// block the next item; a new result waits only while the previous is still stalled
// depends on vns_pkg, vns_ctrl, vns_dp, vns_ram
`timescale 1ns / 1ps

module vertex_normal_smoothing_core #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  vns_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_stall,
    output vns_pkg::out_item_t result
);

    import vns_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // controller
    vns_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .stat         (stat),
        .cmd          (cmd)
    );

    // datapath
    vns_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item),
        .cmd        (cmd),
        .stat       (stat),
        .result_out (result)
    );

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status != ST_OK))
            |-> ((result.norm_x == 16'd0) && (result.norm_y == 16'd0)
                 && (result.norm_z == 16'd0)))
        else $error("error result carries a nonzero normal");

endmodule
